// ===== hw/rtl/fwcv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwcv_pkg
// shared types, codes and the crc-32 byte step of the image chunk verifier
// ----------------------------------------------------------------------------
package fwcv_pkg;

   localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
   localparam logic [6:0]  FULL_PERCENT  = 7'd100;
   localparam logic [6:0]  PROGRESS_STEP = 7'd5;
   localparam int          QUEUE_DEPTH   = 2;

   localparam int MAX_SIZE_W = 24;

   // result status codes
   localparam logic [2:0] STATUS_OK             = 3'd0;
   localparam logic [2:0] STATUS_SIZE_INVALID   = 3'd1;
   localparam logic [2:0] STATUS_CHUNK_CRC_FAIL = 3'd2;
   localparam logic [2:0] STATUS_OFFSET_MISMATCH = 3'd3;
   localparam logic [2:0] STATUS_SIZE_MISMATCH  = 3'd4;
   localparam logic [2:0] STATUS_IMAGE_CRC_FAIL = 3'd5;

   typedef enum logic [1:0] {
      MODE_ANNOUNCE  = 2'd0,
      MODE_DATA      = 2'd1,
      MODE_CHUNK_END = 2'd2,
      MODE_FINISH    = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  data_byte;
      logic [31:0] file_size;
      logic [31:0] chunk_offset;
      logic [31:0] chunk_crc;
      logic [31:0] expected_crc;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  progress;
      logic        progress_report;
      logic [31:0] image_crc;
      logic        apply_request;
   } rsp_type;

   // classified beat handed from front to back
   typedef struct packed {
      mode_type    op;
      logic        size_ok;
      logic [7:0]  data_byte;
      logic [31:0] word;       // file size, chunk offset or expected crc
      logic [31:0] chunk_crc;
   } cmd_type;

   // reflected crc-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                            input logic [7:0]  data);
      logic [31:0] crc;
      crc = crc_in ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fwcv_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwcv_front
// input handshake, capacity register and classification of each beat
// ----------------------------------------------------------------------------
module fwcv_front (
   input  wire  logic                clock,
   input  wire  logic                reset,
   input  wire  logic                req_valid,
   output logic                      req_ready,
   input  wire  fwcv_pkg::req_type   req_data,
   input  wire  logic                csr_wr_en,
   input  wire  logic [23:0]         csr_wr_data,
   input  wire  logic                queue_full,
   output logic                      push,
   output fwcv_pkg::cmd_type         push_cmd
);
   import fwcv_pkg::*;

   logic [MAX_SIZE_W-1:0] max_size_ff;
   logic [MAX_SIZE_W-1:0] max_size_in;

   always_comb begin
      max_size_in = csr_wr_en ? csr_wr_data : max_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff <= '0;
      end else begin
         max_size_ff <= max_size_in;
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_cmd.op        = mode_type'(req_data.mode);
      push_cmd.data_byte = req_data.data_byte;
      push_cmd.chunk_crc = req_data.chunk_crc;
      push_cmd.size_ok   = (max_size_ff != '0) && (req_data.file_size != 32'd0) &&
                           (req_data.file_size <= {{(32-MAX_SIZE_W){1'b0}}, max_size_ff});
      case (mode_type'(req_data.mode))
         MODE_ANNOUNCE:  push_cmd.word = req_data.file_size;
         MODE_CHUNK_END: push_cmd.word = req_data.chunk_offset;
         MODE_FINISH:    push_cmd.word = req_data.expected_crc;
         default:        push_cmd.word = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/fwcv_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwcv_queue
// short fifo of classified beats between front and back
// ----------------------------------------------------------------------------
module fwcv_queue #(
   parameter int Depth = fwcv_pkg::QUEUE_DEPTH
) (
   input  wire  logic                clock,
   input  wire  logic                reset,
   input  wire  logic                push,
   input  wire  fwcv_pkg::cmd_type   push_cmd,
   output logic                      full,
   output logic                      not_empty,
   input  wire  logic                pop,
   output fwcv_pkg::cmd_type         head_cmd
);
   import fwcv_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   cmd_type         entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full      = (count_ff == FullCnt);
   assign not_empty = (count_ff != '0);
   assign head_cmd  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/fwcv_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fwcv_back
// session state, crc accumulation, checks, progress divider and result register
// ----------------------------------------------------------------------------
module fwcv_back (
   input  wire  logic                clock,
   input  wire  logic                reset,
   input  wire  logic                cmd_valid,
   input  wire  fwcv_pkg::cmd_type   cmd,
   output logic                      cmd_pop,
   output logic                      rsp_valid,
   input  wire  logic                rsp_ready,
   output fwcv_pkg::rsp_type         rsp_data
);
   import fwcv_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_RESULT
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] image_size_ff, image_size_in;
   logic [31:0] write_offset_ff, write_offset_in;
   logic [31:0] committed_crc_ff, committed_crc_in;
   logic [31:0] pending_crc_ff, pending_crc_in;
   logic [31:0] chunk_acc_ff, chunk_acc_in;
   logic [15:0] chunk_len_ff, chunk_len_in;
   logic [6:0]  last_progress_ff, last_progress_in;
   logic [38:0] rem_ff, rem_in;
   logic [38:0] div_ff, div_in;
   logic [6:0]  quot_ff, quot_in;
   logic [2:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        out_free;
   logic        emit;
   logic        ge;
   logic        report;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in         = state_ff;
      image_size_in    = image_size_ff;
      write_offset_in  = write_offset_ff;
      committed_crc_in = committed_crc_ff;
      pending_crc_in   = pending_crc_ff;
      chunk_acc_in     = chunk_acc_ff;
      chunk_len_in     = chunk_len_ff;
      last_progress_in = last_progress_ff;
      rem_in           = rem_ff;
      div_in           = div_ff;
      quot_in          = quot_ff;
      step_in          = step_ff;
      rsp_in           = rsp_ff;
      cmd_pop          = 1'b0;
      emit             = 1'b0;
      ge               = (rem_ff >= div_ff);
      report           = (quot_ff >= last_progress_ff + PROGRESS_STEP) ||
                         (quot_ff == FULL_PERCENT);

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && (cmd.op == MODE_DATA || out_free)) begin
               cmd_pop = 1'b1;
               // data beats leave a waiting response untouched
               if (cmd.op != MODE_DATA) begin
                  rsp_in.status          = STATUS_OK;
                  rsp_in.progress        = last_progress_ff;
                  rsp_in.progress_report = 1'b0;
                  rsp_in.image_crc       = committed_crc_ff;
                  rsp_in.apply_request   = 1'b0;
               end
               unique case (cmd.op)
                  MODE_DATA: begin
                     chunk_acc_in   = crc_byte(chunk_acc_ff, cmd.data_byte);
                     pending_crc_in = crc_byte(pending_crc_ff, cmd.data_byte);
                     chunk_len_in   = chunk_len_ff + 16'd1;
                  end
                  MODE_ANNOUNCE: begin
                     emit = 1'b1;
                     if (!cmd.size_ok) begin
                        rsp_in.status = STATUS_SIZE_INVALID;
                     end else begin
                        image_size_in    = cmd.word;
                        write_offset_in  = '0;
                        committed_crc_in = '0;
                        last_progress_in = '0;
                        pending_crc_in   = '1;
                        chunk_acc_in     = '1;
                        chunk_len_in     = '0;
                        rsp_in.progress  = '0;
                        rsp_in.image_crc = '0;
                     end
                  end
                  MODE_CHUNK_END: begin
                     chunk_acc_in   = '1;
                     chunk_len_in   = '0;
                     pending_crc_in = ~committed_crc_ff;
                     if (~chunk_acc_ff != cmd.chunk_crc) begin
                        emit          = 1'b1;
                        rsp_in.status = STATUS_CHUNK_CRC_FAIL;
                     end else if (write_offset_ff != cmd.word) begin
                        emit          = 1'b1;
                        rsp_in.status = STATUS_OFFSET_MISMATCH;
                     end else begin
                        // pending crc becomes the committed one, so it stays as is
                        committed_crc_in = ~pending_crc_ff;
                        pending_crc_in   = pending_crc_ff;
                        write_offset_in  = write_offset_ff + {16'd0, chunk_len_ff};
                        state_in         = ST_MUL;
                     end
                  end
                  MODE_FINISH: begin
                     emit = 1'b1;
                     if (image_size_ff == '0 || write_offset_ff != image_size_ff) begin
                        rsp_in.status = STATUS_SIZE_MISMATCH;
                     end else if (cmd.word != committed_crc_ff) begin
                        rsp_in.status = STATUS_IMAGE_CRC_FAIL;
                     end else begin
                        rsp_in.apply_request = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            if (image_size_ff == '0) begin
               quot_in  = '0;
               state_in = ST_RESULT;
            end else if (write_offset_ff >= image_size_ff) begin
               quot_in  = FULL_PERCENT;
               state_in = ST_RESULT;
            end else begin
               rem_in   = 39'(write_offset_ff) * 39'(FULL_PERCENT);
               div_in   = {1'b0, image_size_ff, 6'd0};
               quot_in  = '0;
               step_in  = 3'd6;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (ge) begin
               rem_in = rem_ff - div_ff;
            end
            div_in  = div_ff >> 1;
            quot_in = {quot_ff[5:0], ge};
            step_in = step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               emit = 1'b1;
               if (report) begin
                  last_progress_in = quot_ff;
               end
               rsp_in.status          = STATUS_OK;
               rsp_in.progress        = report ? quot_ff : last_progress_ff;
               rsp_in.progress_report = report;
               rsp_in.image_crc       = committed_crc_ff;
               rsp_in.apply_request   = 1'b0;
               state_in               = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         image_size_ff    <= '0;
         write_offset_ff  <= '0;
         committed_crc_ff <= '0;
         pending_crc_ff   <= '1;
         chunk_acc_ff     <= '1;
         chunk_len_ff     <= '0;
         last_progress_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         image_size_ff    <= image_size_in;
         write_offset_ff  <= write_offset_in;
         committed_crc_ff <= committed_crc_in;
         pending_crc_ff   <= pending_crc_in;
         chunk_acc_ff     <= chunk_acc_in;
         chunk_len_ff     <= chunk_len_in;
         last_progress_ff <= last_progress_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/firmware_image_chunk_verifier_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// firmware_image_chunk_verifier_unit
// receives a firmware image in chunks and checks it with crc-32
// ----------------------------------------------------------------------------
// Every request beat carries a mode: announce opens a session after checking
// the file size against the partition capacity in csr_wr_data (zero capacity
// means no update), data beats carry one image byte each, chunk end checks the
// chunk crc and then the offset and commits the chunk, finish checks the total
// size and the whole-image crc and raises apply_request on success. Data beats
// give no response; every other beat gives exactly one. Data beats are taken
// and absorbed at one beat per cycle while the back end is idle. Announce and
// finish are handled in the back end's idle state, as is a rejected chunk end.
// An accepted chunk end steps through the checks, the offset times 100
// product, the restoring divider that works out the percentage, and the
// posting of the result. When the image size is zero or the offset has
// reached it the divider is skipped.
// A beat that gives a response also waits in the back end until the response
// register is free or being emptied by rsp_ready; data beats keep flowing
// while a result waits. A queue of QueueDepth classified beats sits between
// the front end and the back end. Progress is reported when it grows by at
// least 5 percent or reaches 100. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module firmware_image_chunk_verifier_unit #(
   parameter int QueueDepth = fwcv_pkg::QUEUE_DEPTH
) (
   input  wire  logic                clock,
   input  wire  logic                reset,
   // request beats
   input  wire  logic                req_valid,
   output logic                      req_ready,
   input  wire  fwcv_pkg::req_type   req_data,
   // response beats
   output logic                      rsp_valid,
   input  wire  logic                rsp_ready,
   output fwcv_pkg::rsp_type         rsp_data,
   // capacity register
   input  wire  logic                csr_wr_en,
   input  wire  logic [23:0]         csr_wr_data
);
   import fwcv_pkg::*;

   logic    push;
   cmd_type push_cmd;
   logic    queue_full;
   logic    queue_not_empty;
   logic    pop;
   cmd_type head_cmd;

   // front end: handshake, capacity register, mode decode and size check
   fwcv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // decoupling queue
   fwcv_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .pop       (pop),
      .head_cmd  (head_cmd)
   );

   // back end: session state, crc, checks, progress and response register
   fwcv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
